@@ design/aocma_pkg.sv @@
// ----------------------------------------------------------------------------
// aocma_pkg
// Shared types and constants of the accelerometer offset calibration and
// moving average core.
// ----------------------------------------------------------------------------
package aocma_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int Q_W         = 16;
	localparam int GRAVITY_W   = 10;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 10;
	localparam int AXES        = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_AVERAGE_ENABLE   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY_Z_COUNTS = 1'd1;

	localparam logic [GRAVITY_W-1:0] GRAVITY_Z_RESET = 10'd240;

	localparam logic OP_CAL  = 1'b0;
	localparam logic OP_MEAS = 1'b1;

	typedef enum logic [1:0] {
		DIV_ONE,
		DIV_WIN,
		DIV_CAL
	} div_sel_t;

	typedef struct packed {
		logic     advance;
		div_sel_t sel;
	} div_ctl_t;

endpackage

@@ design/aocma_div.sv @@
// ----------------------------------------------------------------------------
// aocma_div
// Three-stage pipelined division of a magnitude by a constant divisor, using a
// reciprocal multiply followed by a single remainder correction.
// ----------------------------------------------------------------------------
module aocma_div
	import aocma_pkg::*;
#(
	parameter int A_W         = 26,
	parameter int CAL_DIVISOR = 1000,
	parameter int WIN_DIVISOR = 10
) (
	input  logic           clk,
	input  div_ctl_t       ctl,
	input  logic [A_W-1:0] mag,
	input  logic           neg,
	output logic [Q_W-1:0] quot,
	output logic           quot_neg
);

	localparam int K    = A_W;
	localparam int R_W  = K + 1;
	localparam int P_W  = A_W + R_W;
	localparam int DMAX = (CAL_DIVISOR > WIN_DIVISOR) ? CAL_DIVISOR : WIN_DIVISOR;
	localparam int DW   = $clog2(DMAX + 1);
	localparam int P2_W = Q_W + DW;

	localparam logic [R_W-1:0] RECIP_CAL = R_W'((64'd1 << K) / CAL_DIVISOR);
	localparam logic [R_W-1:0] RECIP_WIN = R_W'((64'd1 << K) / WIN_DIVISOR);
	localparam logic [R_W-1:0] RECIP_ONE = R_W'(64'd1 << K);

	function automatic logic [R_W-1:0] recip_of(input div_sel_t sel);
		logic [R_W-1:0] r;
		unique case (sel)
			DIV_CAL: r = RECIP_CAL;
			DIV_WIN: r = RECIP_WIN;
			default: r = RECIP_ONE;
		endcase
		return r;
	endfunction

	function automatic logic [DW-1:0] divisor_of(input div_sel_t sel);
		logic [DW-1:0] d;
		unique case (sel)
			DIV_CAL: d = DW'(CAL_DIVISOR);
			DIV_WIN: d = DW'(WIN_DIVISOR);
			default: d = DW'(1);
		endcase
		return d;
	endfunction

	logic [P_W-1:0]  prod;
	logic [Q_W-1:0]  q0_s3, q0_s4, quot_s5;
	logic [A_W-1:0]  mag_s3, mag_s4;
	div_sel_t        sel_s3, sel_s4;
	logic            neg_s3, neg_s4, neg_s5;
	logic [P2_W-1:0] prod2_s4;
	logic [P2_W-1:0] rem;
	logic            inc;

	// The reciprocal is rounded down, so the estimate is exact or one short.
	assign prod = P_W'(mag) * P_W'(recip_of(ctl.sel));
	assign rem  = P2_W'(mag_s4) - prod2_s4;
	assign inc  = (rem >= P2_W'(divisor_of(sel_s4)));

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			q0_s3    <= prod[K +: Q_W];
			mag_s3   <= mag;
			sel_s3   <= ctl.sel;
			neg_s3   <= neg;
			prod2_s4 <= P2_W'(q0_s3) * P2_W'(divisor_of(sel_s3));
			q0_s4    <= q0_s3;
			mag_s4   <= mag_s3;
			sel_s4   <= sel_s3;
			neg_s4   <= neg_s3;
			quot_s5  <= q0_s4 + Q_W'(inc);
			neg_s5   <= neg_s4;
		end
	end

	assign quot     = quot_s5;
	assign quot_neg = neg_s5;

endmodule

@@ design/accel_offset_cal_moving_average_core.sv @@
// ----------------------------------------------------------------------------
// accel_offset_cal_moving_average_core
// Three-axis accelerometer offset calibration with an optional moving average.
// ----------------------------------------------------------------------------
// A measurement transaction yields a result; calibration transactions produce
// no result.
// Throughput: one transaction per cycle, set by the six-stage pipeline of input
// register, running sums, reciprocal multiply, correction multiply, remainder
// fix and output register. The whole pipeline holds while a result is stalled.
// Reset clears the window ring, all sums, offsets and control state at once.
module accel_offset_cal_moving_average_core
	import aocma_pkg::*;
#(
	parameter int WINDOW      = 10,
	parameter int CAL_SAMPLES = 1000
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic                       op,
	input  logic signed [SAMPLE_W-1:0] x_sample,
	input  logic signed [SAMPLE_W-1:0] y_sample,
	input  logic signed [SAMPLE_W-1:0] z_sample,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [SAMPLE_W-1:0] x_out,
	output logic signed [SAMPLE_W-1:0] y_out,
	output logic signed [SAMPLE_W-1:0] z_out,
	output logic                       offsets_valid
);

	localparam int WS_W  = SAMPLE_W + $clog2(WINDOW);
	localparam int CS_W  = SAMPLE_W + $clog2(CAL_SAMPLES);
	localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam int A_W   = (CS_W > WS_W) ? CS_W : WS_W;
	localparam int V_W   = Q_W + 2;
	localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [V_W-1:0] v);
		logic signed [V_W-1:0] hi;
		logic signed [V_W-1:0] lo;
		hi = V_W'((2 ** (SAMPLE_W - 1)) - 1);
		lo = -hi - V_W'(1);
		priority if (v > hi) begin
			return hi[SAMPLE_W-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_W-1:0];
		end else begin
			return v[SAMPLE_W-1:0];
		end
	endfunction

	// Configuration registers.
	logic                 average_enable_q;
	logic [GRAVITY_W-1:0] gravity_z_counts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_enable_q   <= 1'b0;
			gravity_z_counts_q <= GRAVITY_Z_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AVERAGE_ENABLE:   average_enable_q   <= cfg_data[0];
				CFG_GRAVITY_Z_COUNTS: gravity_z_counts_q <= cfg_data[GRAVITY_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic result_valid_s6;

	assign en           = !(result_valid_s6 && result_stall);
	assign sample_stall = !en;

	// Stage 1: input register.
	logic                       v_s1;
	logic                       op_s1;
	logic signed [SAMPLE_W-1:0] smp_s1 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && sample_valid) begin
			op_s1     <= op;
			smp_s1[0] <= x_sample;
			smp_s1[1] <= y_sample;
			smp_s1[2] <= z_sample;
		end
	end

	// Stage 2: running sums. The window ring is a shift line; its last tap is
	// the sample that leaves the window.
	logic signed [CS_W-1:0]     cal_sum_q   [AXES];
	logic signed [WS_W-1:0]     win_sum_q   [AXES];
	logic signed [SAMPLE_W-1:0] ring_q      [AXES][WINDOW];
	logic [CNT_W-1:0]           cal_count_q;
	logic signed [CS_W-1:0]     cal_sum_nxt [AXES];
	logic signed [WS_W-1:0]     win_sum_nxt [AXES];
	logic signed [A_W-1:0]      div_val     [AXES];
	logic [A_W-1:0]             div_mag     [AXES];
	logic                       cal_done;
	logic                       need_div;
	div_sel_t                   sel_nxt;

	assign cal_done = (cal_count_q == CAL_LAST);
	assign need_div = (op_s1 == OP_MEAS) || cal_done;

	always_comb begin
		priority if (op_s1 == OP_CAL) begin
			sel_nxt = DIV_CAL;
		end else if (average_enable_q) begin
			sel_nxt = DIV_WIN;
		end else begin
			sel_nxt = DIV_ONE;
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			cal_sum_nxt[a] = cal_sum_q[a] + CS_W'(smp_s1[a]);
			win_sum_nxt[a] = win_sum_q[a] + WS_W'(smp_s1[a]) - WS_W'(ring_q[a][WINDOW-1]);
			unique case (sel_nxt)
				DIV_CAL: div_val[a] = A_W'(cal_sum_nxt[a]);
				DIV_WIN: div_val[a] = A_W'(win_sum_nxt[a]);
				default: div_val[a] = A_W'(smp_s1[a]);
			endcase
			div_mag[a] = div_val[a][A_W-1] ? A_W'(-div_val[a]) : A_W'(div_val[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_count_q <= '0;
			for (int a = 0; a < AXES; a++) begin
				cal_sum_q[a] <= '0;
				win_sum_q[a] <= '0;
				for (int i = 0; i < WINDOW; i++) begin
					ring_q[a][i] <= '0;
				end
			end
		end else if (en && v_s1) begin
			if (op_s1 == OP_CAL) begin
				if (cal_done) begin
					cal_count_q <= '0;
					for (int a = 0; a < AXES; a++) begin
						cal_sum_q[a] <= '0;
					end
				end else begin
					cal_count_q <= cal_count_q + CNT_W'(1);
					for (int a = 0; a < AXES; a++) begin
						cal_sum_q[a] <= cal_sum_nxt[a];
					end
				end
			end else if (average_enable_q) begin
				for (int a = 0; a < AXES; a++) begin
					win_sum_q[a] <= win_sum_nxt[a];
					ring_q[a][0] <= smp_s1[a];
					for (int i = 1; i < WINDOW; i++) begin
						ring_q[a][i] <= ring_q[a][i-1];
					end
				end
			end
		end
	end

	// Only measurements and completed calibration runs continue down the pipe.
	logic           v_s2, v_s3, v_s4, v_s5;
	logic           lat_s2, lat_s3, lat_s4, lat_s5;
	div_sel_t       sel_s2;
	logic [A_W-1:0] mag_s2 [AXES];
	logic           neg_s2 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			lat_s2 <= 1'b0;
			lat_s3 <= 1'b0;
			lat_s4 <= 1'b0;
			lat_s5 <= 1'b0;
		end else if (en) begin
			v_s2   <= v_s1 && need_div;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			lat_s2 <= (op_s1 == OP_CAL);
			lat_s3 <= lat_s2;
			lat_s4 <= lat_s3;
			lat_s5 <= lat_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s2 <= sel_nxt;
			for (int a = 0; a < AXES; a++) begin
				mag_s2[a] <= div_mag[a];
				neg_s2[a] <= div_val[a][A_W-1];
			end
		end
	end

	// Stages 3 to 5: one divider per axis.
	div_ctl_t       div_ctl;
	logic [Q_W-1:0] q_s5   [AXES];
	logic           neg_s5 [AXES];

	assign div_ctl.advance = en;
	assign div_ctl.sel     = sel_s2;

	for (genvar a = 0; a < AXES; a++) begin : g_div
		aocma_div #(
			.A_W         (A_W),
			.CAL_DIVISOR (CAL_SAMPLES),
			.WIN_DIVISOR (WINDOW)
		) u_div (
			.clk      (clk),
			.ctl      (div_ctl),
			.mag      (mag_s2[a]),
			.neg      (neg_s2[a]),
			.quot     (q_s5[a]),
			.quot_neg (neg_s5[a])
		);
	end

	// Stage 6: offset latch or offset subtraction. A calibration run writes the
	// offsets here, in the same stage where measurements read them, so every
	// measurement sees the offsets of the runs that came before it.
	logic signed [SAMPLE_W-1:0] offset_q  [AXES];
	logic                       calibrated_q;
	logic signed [SAMPLE_W-1:0] out_s6    [AXES];
	logic                       offsets_valid_s6;
	logic signed [Q_W:0]        q_signed  [AXES];
	logic signed [V_W-1:0]      meas_val  [AXES];
	logic signed [V_W-1:0]      off_val   [AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			q_signed[a] = neg_s5[a] ? -$signed({1'b0, q_s5[a]}) : $signed({1'b0, q_s5[a]});
			meas_val[a] = V_W'(q_signed[a]) - V_W'(offset_q[a]);
			off_val[a]  = V_W'(q_signed[a]);
		end
		off_val[AXES-1] = V_W'(q_signed[AXES-1]) - $signed(V_W'(gravity_z_counts_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calibrated_q    <= 1'b0;
			result_valid_s6 <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				offset_q[a] <= '0;
			end
		end else if (en) begin
			result_valid_s6 <= v_s5 && !lat_s5;
			if (v_s5 && lat_s5) begin
				calibrated_q <= 1'b1;
				for (int a = 0; a < AXES; a++) begin
					offset_q[a] <= sat_sample(off_val[a]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s5 && !lat_s5) begin
			offsets_valid_s6 <= calibrated_q;
			for (int a = 0; a < AXES; a++) begin
				out_s6[a] <= sat_sample(meas_val[a]);
			end
		end
	end

	assign result_valid  = result_valid_s6;
	assign x_out         = out_s6[0];
	assign y_out         = out_s6[1];
	assign z_out         = out_s6[2];
	assign offsets_valid = offsets_valid_s6;

	// The last calibration sample of a run restarts the count.
	a_cal_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s1 && (op_s1 == OP_CAL) && cal_done) |=> (cal_count_q == '0))
		else $error("calibration count did not restart after a full run");

	// Only completed calibration runs use the calibration divisor.
	a_sel_match: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (lat_s2 == (sel_s2 == DIV_CAL)))
		else $error("divisor select does not match the transaction kind");

	// An offset latch gives no result and marks the offsets as valid.
	a_latch_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s5 && lat_s5) |=> (!result_valid_s6 && calibrated_q))
		else $error("offset latch produced a result or left offsets invalid");

	// Once set, the calibrated flag stays set until reset.
	a_cal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(calibrated_q) |-> calibrated_q)
		else $error("calibrated flag dropped");

endmodule

@@ dv/accel_offset_cal_moving_average_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_offset_cal_moving_average_core_tb
// Self-checking bench for the accelerometer offset calibration core. Samples
// go in over the valid/stall channel while a scoreboard class keeps its own
// copy of the window ring, calibration sums and offsets and predicts every
// measurement result. Short directed checks come first. Random phases follow,
// with a register update between each pair of phases and random idle bursts
// on both channels.
// ----------------------------------------------------------------------------
module accel_offset_cal_moving_average_core_tb;
	import aocma_pkg::*;

	localparam int WINDOW         = 10;
	localparam int CAL_SAMPLES    = 1000;
	localparam int RESET_CYCLES   = 8;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 300;
	localparam int CAL_PERCENT    = 88;
	localparam int SETTLE_CYCLES  = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic signed [Q_W-1:0] x;
		logic signed [Q_W-1:0] y;
		logic signed [Q_W-1:0] z;
		logic                  ov;
	} accel_result_t;

	// Value spread of the calibration samples, chosen per calibration run.
	typedef enum int {
		CAL_PINNED,
		CAL_FULL,
		CAL_NARROW
	} cal_spread_t;

	class cal_avg_scoreboard #(int WIN = 10, int CAL_N = 1000);
		bit            avg_on;
		int            gravity;
		int            ring [AXES][WIN];
		int            win_sum [AXES];
		int            ring_pos;
		int            cal_n;
		longint        cal_acc [AXES];
		int            offset [AXES];
		bit            offsets_ok;
		accel_result_t pending_out [$];
		int            mismatches;
		int            cal_seen;
		int            meas_seen;
		int            latches;
		int            checked;

		function new();
			gravity = GRAVITY_Z_RESET;
		endfunction

		static function int clip16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return int'(v);
		endfunction

		function void set_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == CFG_AVERAGE_ENABLE)
				avg_on = data[0];
			else
				gravity = data;
		endfunction

		function void take_sample(logic o, logic signed [SAMPLE_W-1:0] xs,
				logic signed [SAMPLE_W-1:0] ys, logic signed [SAMPLE_W-1:0] zs);
			int            s [AXES];
			int            val [AXES];
			accel_result_t r;
			s[0] = xs;
			s[1] = ys;
			s[2] = zs;
			if (o == OP_CAL) begin
				cal_seen++;
				for (int a = 0; a < AXES; a++)
					cal_acc[a] += s[a];
				cal_n++;
				if (cal_n >= CAL_N) begin
					for (int a = 0; a < AXES; a++) begin
						offset[a] = clip16(cal_acc[a] / CAL_N - ((a == 2) ? gravity : 0));
						cal_acc[a] = 0;
					end
					offsets_ok = 1'b1;
					cal_n = 0;
					latches++;
				end
				return;
			end
			meas_seen++;
			if (avg_on) begin
				for (int a = 0; a < AXES; a++) begin
					win_sum[a] += s[a] - ring[a][ring_pos];
					ring[a][ring_pos] = s[a];
					val[a] = win_sum[a] / WIN;
				end
				ring_pos = (ring_pos + 1) % WIN;
			end else begin
				val = s;
			end
			r.x  = Q_W'(clip16(val[0] - offset[0]));
			r.y  = Q_W'(clip16(val[1] - offset[1]));
			r.z  = Q_W'(clip16(val[2] - offset[2]));
			r.ov = offsets_ok;
			pending_out.push_back(r);
		endfunction

		function void compare_output(accel_result_t got);
			accel_result_t want;
			if (pending_out.size() == 0) begin
				$error("result with nothing pending: x=%0d y=%0d z=%0d ov=%0b",
					got.x, got.y, got.z, got.ov);
				mismatches++;
				return;
			end
			want = pending_out.pop_front();
			checked++;
			if (got.x !== want.x) begin
				$error("x_out: expected %0d, got %0d", want.x, got.x);
				mismatches++;
			end
			if (got.y !== want.y) begin
				$error("y_out: expected %0d, got %0d", want.y, got.y);
				mismatches++;
			end
			if (got.z !== want.z) begin
				$error("z_out: expected %0d, got %0d", want.z, got.z);
				mismatches++;
			end
			if (got.ov !== want.ov) begin
				$error("offsets_valid: expected %0b, got %0b", want.ov, got.ov);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       sample_valid;
	logic                       sample_stall;
	logic                       op;
	logic signed [SAMPLE_W-1:0] x_sample;
	logic signed [SAMPLE_W-1:0] y_sample;
	logic signed [SAMPLE_W-1:0] z_sample;
	logic                       result_valid;
	logic                       result_stall;
	logic signed [SAMPLE_W-1:0] x_out;
	logic signed [SAMPLE_W-1:0] y_out;
	logic signed [SAMPLE_W-1:0] z_out;
	logic                       offsets_valid;

	cal_avg_scoreboard #(WINDOW, CAL_SAMPLES) sb;
	bit gaps_on;

	accel_offset_cal_moving_average_core #(
		.WINDOW      (WINDOW),
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.op            (op),
		.x_sample      (x_sample),
		.y_sample      (y_sample),
		.z_sample      (z_sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.x_out         (x_out),
		.y_out         (y_out),
		.z_out         (z_out),
		.offsets_valid (offsets_valid)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver back-pressure in random bursts.
	initial begin : result_backpressure
		int stall_left;
		stall_left = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (gaps_on && arst_n && $urandom_range(0, 11) == 0)
				stall_left = $urandom_range(1, 19);
			result_stall <= (stall_left > 0);
		end
	end

	// Outputs are sampled mid-cycle; a transaction completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && result_valid !== 1'b0 && result_stall === 1'b0)
			sb.compare_output({x_out, y_out, z_out, offsets_valid});
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("accel_offset_cal_moving_average_core_tb: done, errors");
		$finish;
	end

	task automatic send_sample(input logic o, input logic signed [SAMPLE_W-1:0] xs,
			input logic signed [SAMPLE_W-1:0] ys, input logic signed [SAMPLE_W-1:0] zs);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		op           <= o;
		x_sample     <= xs;
		y_sample     <= ys;
		z_sample     <= zs;
		@(negedge clk);
		while (sample_stall !== 1'b0)
			@(negedge clk);
		sb.take_sample(o, xs, ys, zs);
		@(posedge clk);
	endtask

	// Parks the input channel until every predicted result has come out.
	task automatic hold_until_empty(input int extra);
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_out.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic load_settings(input logic avg, input logic [GRAVITY_W-1:0] grav);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_AVERAGE_ENABLE;
		cfg_data  <= CFG_DATA_W'(avg);
		@(posedge clk);
		cfg_index <= CFG_GRAVITY_Z_COUNTS;
		cfg_data  <= CFG_DATA_W'(grav);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(CFG_AVERAGE_ENABLE, CFG_DATA_W'(avg));
		sb.set_config(CFG_GRAVITY_Z_COUNTS, CFG_DATA_W'(grav));
	endtask

	function automatic logic signed [SAMPLE_W-1:0] span_value(input int lo, input int hi);
		return SAMPLE_W'(lo + int'($urandom_range(hi - lo, 0)));
	endfunction

	// Measurement axis value with a bias toward the range ends.
	function automatic logic signed [SAMPLE_W-1:0] meas_value();
		logic [SAMPLE_W-1:0] v;
		v = SAMPLE_W'($urandom());
		case ($urandom_range(0, 7))
			0: v = 16'h8000;
			1: v = 16'h7fff;
			2: v = {SAMPLE_W{v[0]}};
			default: ;
		endcase
		return v;
	endfunction

	initial begin : stimulus
		logic        o;
		cal_spread_t spread;
		logic signed [SAMPLE_W-1:0] xs;
		logic signed [SAMPLE_W-1:0] ys;
		logic signed [SAMPLE_W-1:0] zs;
		logic [GRAVITY_W-1:0] grav;

		sb = new();
		gaps_on = 1'b1;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= CFG_AVERAGE_ENABLE;
		cfg_data     <= '0;
		sample_valid <= 1'b0;
		op           <= OP_CAL;
		x_sample     <= '0;
		y_sample     <= '0;
		z_sample     <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Raw path with reset settings: offsets are still zero and not valid.
		send_sample(OP_MEAS, 16'sd32767, -16'sd32768, 16'sd0);
		send_sample(OP_MEAS, -16'sd32768, 16'sd32767, -16'sd1);
		send_sample(OP_MEAS, 16'sd0, 16'sd1, -16'sd32768);
		send_sample(OP_MEAS, -16'sd1, -16'sd1, 16'sd32767);
		// A partial calibration run must leave the offsets alone.
		send_sample(OP_CAL, 16'sd32767, -16'sd32768, 16'sd12345);
		send_sample(OP_CAL, -16'sd32768, 16'sd32767, -16'sd12345);
		send_sample(OP_MEAS, 16'sd100, -16'sd100, 16'sd5);

		// Window warm-up from an all-zero ring, then a swing to the other extreme.
		hold_until_empty(SETTLE_CYCLES);
		load_settings(1'b1, GRAVITY_Z_RESET);
		repeat (11) send_sample(OP_MEAS, 16'sd32767, -16'sd32768, 16'sd32767);
		repeat (3) send_sample(OP_MEAS, -16'sd32768, 16'sd32767, -16'sd32768);

		for (int phase = 0; phase < PHASES; phase++) begin
			hold_until_empty(SETTLE_CYCLES);
			case (phase % 4)
				0: grav = '1;
				1: grav = '0;
				2: grav = GRAVITY_W'($urandom_range(1, 1022));
				default: grav = GRAVITY_Z_RESET;
			endcase
			load_settings(phase[0], grav);
			gaps_on = (phase != PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					hold_until_empty(0);
				o = ($urandom_range(0, 99) < CAL_PERCENT) ? OP_CAL : OP_MEAS;
				if (o == OP_CAL) begin
					// The first run pins z low enough that its offset saturates.
					spread = cal_spread_t'(sb.latches % 3);
					case (spread)
						CAL_PINNED: begin
							xs = span_value(32000, 32767);
							ys = span_value(-32768, -32000);
							zs = span_value(-32768, -32500);
						end
						CAL_NARROW: begin
							xs = span_value(-512, 511);
							ys = span_value(-512, 511);
							zs = span_value(-512, 511);
						end
						default: begin
							xs = SAMPLE_W'($urandom());
							ys = SAMPLE_W'($urandom());
							zs = SAMPLE_W'($urandom());
						end
					endcase
				end else begin
					xs = meas_value();
					ys = meas_value();
					zs = meas_value();
				end
				send_sample(o, xs, ys, zs);
			end
		end

		hold_until_empty(2 * SETTLE_CYCLES);
		$display("run: %0d calibration and %0d measurement transactions, %0d offset latches",
			sb.cal_seen, sb.meas_seen, sb.latches);
		$display("run: %0d results compared, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("accel_offset_cal_moving_average_core_tb: done, clean");
		else
			$display("accel_offset_cal_moving_average_core_tb: done, errors");
		$finish;
	end

endmodule
